// ----- rtl/kde_pkg.sv -----
// ----------------------------------------------------------------------------
// kde_pkg
// Shared types, constants and the keypad lookup for the keypad decimal entry.
// ----------------------------------------------------------------------------
package kde_pkg;

	typedef logic [3:0] key_code_t;

	localparam key_code_t KEY_STAR = 4'd10;
	localparam key_code_t KEY_HASH = 4'd11;
	localparam key_code_t KEY_NONE = 4'd15; // column three, no key fitted
	localparam key_code_t KEY_DIGIT_MAX = 4'd9;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] SCALE_BASE_RST = 8'd44;
	localparam logic [7:0] OFFSET_BASE_RST = 8'd52;

	localparam logic TARGET_SCALE = 1'b0;
	localparam logic TARGET_OFFSET = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_SCALE_BASE = 1'b0;
	localparam logic REG_OFFSET_BASE = 1'b1;

	localparam logic [1:0] LAST_DIGIT = 2'd3;
	localparam logic [13:0] VALUE_MAX = 14'd9999;

	typedef struct packed {
		logic       valid;
		logic [1:0] key_column;
		logic [1:0] key_row;
	} key_item_t;

	typedef struct packed {
		logic [13:0] scale_value;
		logic [13:0] offset_value;
		logic        editing_offset;
		logic        echo_valid;
		logic [7:0]  echo_char;
		logic [7:0]  echo_position;
		logic        clear_display;
		logic [7:0]  clear_base;
		logic [1:0]  digits_pending;
	} result_t;

	// 3x4 keypad: columns 1 4 7 *, 2 5 8 0, 3 6 9 #, top row first
	function automatic key_code_t key_lookup(logic [1:0] col, logic [1:0] row);
		key_code_t k;
		unique case ({col, row})
			4'b00_00: k = 4'd1;
			4'b00_01: k = 4'd4;
			4'b00_10: k = 4'd7;
			4'b00_11: k = KEY_STAR;
			4'b01_00: k = 4'd2;
			4'b01_01: k = 4'd5;
			4'b01_10: k = 4'd8;
			4'b01_11: k = 4'd0;
			4'b10_00: k = 4'd3;
			4'b10_01: k = 4'd6;
			4'b10_10: k = 4'd9;
			4'b10_11: k = KEY_HASH;
			default:  k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/kde_if.sv -----
// ----------------------------------------------------------------------------
// kde_key_if / kde_result_if
// Valid/ready channels for key presses and entry results.
// ----------------------------------------------------------------------------
interface kde_key_if;
	logic       valid;
	logic       ready;
	logic [1:0] key_column;
	logic [1:0] key_row;

	modport source (output valid, output key_column, output key_row, input ready);
	modport sink (input valid, input key_column, input key_row, output ready);
endinterface

interface kde_result_if;
	logic        valid;
	logic        ready;
	logic [13:0] scale_value;
	logic [13:0] offset_value;
	logic        editing_offset;
	logic        echo_valid;
	logic [7:0]  echo_char;
	logic [7:0]  echo_position;
	logic        clear_display;
	logic [7:0]  clear_base;
	logic [1:0]  digits_pending;

	modport source (
		output valid, output scale_value, output offset_value, output editing_offset,
		output echo_valid, output echo_char, output echo_position,
		output clear_display, output clear_base, output digits_pending,
		input ready
	);
	modport sink (
		input valid, input scale_value, input offset_value, input editing_offset,
		input echo_valid, input echo_char, input echo_position,
		input clear_display, input clear_base, input digits_pending,
		output ready
	);
endinterface

// ----- rtl/keypad_decimal_entry.sv -----
// ----------------------------------------------------------------------------
// keypad_decimal_entry
// Decimal entry of scale and offset values from a decoded 3x4 keypad.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  key       in   valid/ready        key_column, key_row
//  result    out  valid/ready        values, target, echo, clear, pending
//  apb       in   psel/penable/...   paddr[2] selects scale or offset base
//
//  One request per cycle sustained while results are taken; a key passes the
//  input register, then the entry logic into the result register, before its
//  result is valid.
//  Reset: scale selected, both counts and stores zero, bases 44 and 52.
//  A stalled result holds; the input register still takes one request, then
//  key.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module keypad_decimal_entry (
	input  logic        clk,
	input  logic        arst_n,
	kde_key_if.sink     key,
	kde_result_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// display base cells from the register file
	logic [7:0] scale_base;
	logic [7:0] offset_base;

	// registered key press and the core's take strobe
	kde_pkg::key_item_t item;
	logic               take;

	kde_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.scale_base  (scale_base),
		.offset_base (offset_base)
	);

	kde_input_stage u_input (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.take   (take),
		.item   (item)
	);

	// key lookup, digit buffering, commit and result register
	kde_entry_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.take        (take),
		.scale_base  (scale_base),
		.offset_base (offset_base),
		.result      (result)
	);

endmodule

// ----- rtl/kde_apb_regs.sv -----
// ----------------------------------------------------------------------------
// kde_apb_regs
// APB register file holding the two display base cells.
// ----------------------------------------------------------------------------
module kde_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  scale_base,
	output logic [7:0]  offset_base
);

	logic [7:0] scale_base_q;
	logic [7:0] offset_base_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_base_q <= kde_pkg::SCALE_BASE_RST;
			offset_base_q <= kde_pkg::OFFSET_BASE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				kde_pkg::REG_SCALE_BASE:  scale_base_q <= pwdata[7:0];
				kde_pkg::REG_OFFSET_BASE: offset_base_q <= pwdata[7:0];
				default:                  scale_base_q <= scale_base_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			kde_pkg::REG_SCALE_BASE:  prdata = {24'd0, scale_base_q};
			kde_pkg::REG_OFFSET_BASE: prdata = {24'd0, offset_base_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign scale_base = scale_base_q;
	assign offset_base = offset_base_q;

endmodule

// ----- rtl/kde_input_stage.sv -----
// ----------------------------------------------------------------------------
// kde_input_stage
// Input register for key presses; refills whenever the core takes the item.
// ----------------------------------------------------------------------------
module kde_input_stage (
	input  logic                clk,
	input  logic                arst_n,
	kde_key_if.sink             key,
	input  logic                take,
	output kde_pkg::key_item_t  item
);

	logic       valid_s1;
	logic [1:0] column_s1;
	logic [1:0] row_s1;
	logic       load;

	assign key.ready = !valid_s1 || take;
	assign load = key.valid && key.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key.ready) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			column_s1 <= key.key_column;
			row_s1 <= key.key_row;
		end
	end

	assign item.valid = valid_s1;
	assign item.key_column = column_s1;
	assign item.key_row = row_s1;

endmodule

// ----- rtl/kde_entry_core.sv -----
// ----------------------------------------------------------------------------
// kde_entry_core
// Entry state, digit buffers and result register; one request per cycle while the result is taken.
// ----------------------------------------------------------------------------
module kde_entry_core (
	input  logic               clk,
	input  logic               arst_n,
	input  kde_pkg::key_item_t item,
	output logic               take,
	input  logic [7:0]         scale_base,
	input  logic [7:0]         offset_base,
	kde_result_if.source       result
);

	logic        target_q;
	logic [1:0]  scale_cnt_q;
	logic [1:0]  offset_cnt_q;
	logic [13:0] scale_q;
	logic [13:0] offset_q;
	logic [3:0]  scale_dig_q [3];
	logic [3:0]  offset_dig_q [3];
	logic        res_valid_q;
	kde_pkg::result_t res_q;

	kde_pkg::key_code_t key;
	logic        is_star;
	logic        is_hash;
	logic        is_digit;
	logic        commit;
	logic        next_target;
	logic [1:0]  cnt;
	logic [1:0]  cnt_next;
	logic [7:0]  base;
	logic [3:0]  d0;
	logic [3:0]  d1;
	logic [3:0]  d2;
	logic [13:0] value;
	logic        commit_scale;
	logic        commit_offset;
	kde_pkg::result_t res_d;

	assign take = item.valid && (!res_valid_q || result.ready);

	always_comb begin
		key = kde_pkg::key_lookup(item.key_column, item.key_row);
		is_star = (key == kde_pkg::KEY_STAR);
		is_hash = (key == kde_pkg::KEY_HASH);
		is_digit = (key <= kde_pkg::KEY_DIGIT_MAX);
		cnt = target_q ? offset_cnt_q : scale_cnt_q;
		base = target_q ? offset_base : scale_base;
		d0 = target_q ? offset_dig_q[0] : scale_dig_q[0];
		d1 = target_q ? offset_dig_q[1] : scale_dig_q[1];
		d2 = target_q ? offset_dig_q[2] : scale_dig_q[2];
		commit = is_digit && (cnt == kde_pkg::LAST_DIGIT);
		cnt_next = commit ? 2'd0 : cnt + 2'd1;
		value = 14'(d0) * 14'd1000 + 14'(d1) * 14'd100 + 14'(d2) * 14'd10 + 14'(key);
		commit_scale = commit && (target_q == kde_pkg::TARGET_SCALE);
		commit_offset = commit && (target_q == kde_pkg::TARGET_OFFSET);

		priority if (is_star) begin
			next_target = kde_pkg::TARGET_SCALE;
		end else if (is_hash) begin
			next_target = kde_pkg::TARGET_OFFSET;
		end else begin
			next_target = target_q;
		end

		res_d.scale_value = commit_scale ? value : scale_q;
		res_d.offset_value = commit_offset ? value : offset_q;
		res_d.editing_offset = next_target;
		res_d.echo_valid = is_digit;
		res_d.echo_char = is_digit ? kde_pkg::ASCII_ZERO + 8'(key) : 8'd0;
		res_d.echo_position = is_digit ? base + 8'(cnt) : 8'd0;
		res_d.clear_display = commit;
		res_d.clear_base = commit ? base : 8'd0;
		if (is_digit) begin
			res_d.digits_pending = cnt_next;
		end else begin
			res_d.digits_pending = next_target ? offset_cnt_q : scale_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= kde_pkg::TARGET_SCALE;
			scale_cnt_q <= 2'd0;
			offset_cnt_q <= 2'd0;
			scale_q <= 14'd0;
			offset_q <= 14'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				target_q <= next_target;
				if (is_digit && target_q == kde_pkg::TARGET_SCALE) begin
					scale_cnt_q <= cnt_next;
				end
				if (is_digit && target_q == kde_pkg::TARGET_OFFSET) begin
					offset_cnt_q <= cnt_next;
				end
				if (commit_scale) begin
					scale_q <= value;
				end
				if (commit_offset) begin
					offset_q <= value;
				end
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// digit buffers and result payload: no reset
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
			if (is_digit && !commit && target_q == kde_pkg::TARGET_SCALE) begin
				scale_dig_q[cnt] <= key;
			end
			if (is_digit && !commit && target_q == kde_pkg::TARGET_OFFSET) begin
				offset_dig_q[cnt] <= key;
			end
		end
	end

	assign result.valid = res_valid_q;
	assign result.scale_value = res_q.scale_value;
	assign result.offset_value = res_q.offset_value;
	assign result.editing_offset = res_q.editing_offset;
	assign result.echo_valid = res_q.echo_valid;
	assign result.echo_char = res_q.echo_char;
	assign result.echo_position = res_q.echo_position;
	assign result.clear_display = res_q.clear_display;
	assign result.clear_base = res_q.clear_base;
	assign result.digits_pending = res_q.digits_pending;

`ifndef SYNTHESIS
	a_clear_has_echo: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.clear_display |-> res_q.echo_valid)
		else $error("clear without echo");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.clear_display |-> res_q.digits_pending == 2'd0)
		else $error("digits left after commit");

	a_commit_resets_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		take && commit_scale |=> scale_cnt_q == 2'd0)
		else $error("scale count not cleared on commit");

	a_values_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q <= kde_pkg::VALUE_MAX && offset_q <= kde_pkg::VALUE_MAX)
		else $error("committed value above 9999");
`endif

endmodule
